/* rtl/svm_pkg.sv */
// ----------------------------------------------------------------------------
// svm_pkg: shared types and constants for the sample voice mixer
// Item structs, the internal command format and default sizes.
// ----------------------------------------------------------------------------
package svm_pkg;

	localparam int VOICES_DEF    = 5;
	localparam int SOUNDS_DEF    = 5;
	localparam int ADDR_BITS_DEF = 16;
	localparam int QUEUE_DEPTH   = 4;

	localparam logic [15:0] GAIN_RESET = 16'd3277;
	localparam int          GAIN_SHIFT = 15;

	typedef enum logic [1:0] {
		MODE_MIX  = 2'd0,
		MODE_TRIG = 2'd1,
		MODE_WSMP = 2'd2,
		MODE_WSND = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t              mode;
		logic [2:0]         sound_id;
		logic [15:0]        address;
		logic signed [15:0] sample_word;
		logic [16:0]        sound_length;
		logic               background_valid;
		logic signed [15:0] background_sample;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] left_sample;
		logic signed [15:0] right_sample;
	} out_item_t;

	// data holds the sample word for sample writes, the gated background for mixes
	typedef struct packed {
		mode_t              op;
		logic [2:0]         sid;
		logic [15:0]        addr;
		logic signed [15:0] data;
		logic [16:0]        length;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic fin;
	} back_stat_t;

endpackage

/* rtl/svm_front.sv */
// ----------------------------------------------------------------------------
// svm_front: input item decode
// Accepts items, drops triggers and sound writes with a bad sound number,
// gates the background sample and forms commands for the queue.
// ----------------------------------------------------------------------------
module svm_front import svm_pkg::*; #(
	parameter int SOUNDS = SOUNDS_DEF
) (
	input  logic     in_valid,
	input  in_item_t in_item,
	output logic     in_stall,
	input  logic     q_full,
	output logic     push,
	output cmd_t     cmd
);

	logic accept;
	logic keep;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	always_comb begin
		unique case (in_item.mode)
			MODE_MIX, MODE_WSMP: keep = 1'b1;
			MODE_TRIG, MODE_WSND: keep = (32'(in_item.sound_id) < SOUNDS);
			default: keep = 1'b0;
		endcase
	end

	assign push = accept && keep;

	always_comb begin
		cmd.op     = in_item.mode;
		cmd.sid    = in_item.sound_id;
		cmd.addr   = in_item.address;
		cmd.length = in_item.sound_length;
		if (in_item.mode == MODE_MIX) begin
			cmd.data = in_item.background_valid ? in_item.background_sample : 16'sd0;
		end else begin
			cmd.data = in_item.sample_word;
		end
	end

endmodule

/* rtl/svm_queue.sv */
// ----------------------------------------------------------------------------
// svm_queue: command queue
// Small register FIFO between the decode front and the execution back.
// ----------------------------------------------------------------------------
module svm_queue import svm_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t head_cmd,
	output logic full,
	output logic empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_P = PTR_W'(DEPTH - 1);

	cmd_t             fifo_q [DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign head_cmd = fifo_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == LAST_P) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == LAST_P) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/svm_back.sv */
// ----------------------------------------------------------------------------
// svm_back: command execution
// Holds the sample memory, sound table and voice state. Runs writes and
// triggers when popped and mixes a frame by stepping through the voices
// with a pipelined memory read, multiply and accumulate.
// ----------------------------------------------------------------------------
module svm_back import svm_pkg::*; #(
	parameter int VOICES    = VOICES_DEF,
	parameter int SOUNDS    = SOUNDS_DEF,
	parameter int ADDR_BITS = ADDR_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] gain,
	input  logic        q_empty,
	input  cmd_t        q_cmd,
	output logic        q_pop,
	input  logic        out_stall,
	output logic        out_valid,
	output out_item_t   out_item,
	output back_stat_t  stat
);

	localparam int SID_W  = (SOUNDS > 1) ? $clog2(SOUNDS) : 1;
	localparam int VID_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int PROD_W = 33;
	localparam int PART_W = PROD_W - GAIN_SHIFT;
	localparam int ACC_W  = PART_W + $clog2(VOICES + 1) + 1;
	localparam int DEPTH  = 1 << ADDR_BITS;
	localparam logic [VID_W-1:0] LAST_V = VID_W'(VOICES - 1);
	localparam logic signed [ACC_W-1:0] MAX_V = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0] MIN_V = ACC_W'(-32768);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MIX,
		ST_DRAIN,
		ST_FIN
	} state_t;

	state_t                    state_q;
	logic [VID_W-1:0]          vidx_q;
	logic                      drain_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic                      act_s1;
	logic                      act_s2;
	logic signed [15:0]        smp_s1;
	logic signed [PROD_W-1:0]  prod_s2;
	logic                      out_valid_q;
	out_item_t                 out_item_q;

	logic signed [15:0]        mem [DEPTH];
	logic [ADDR_BITS-1:0]      snd_start_q [SOUNDS];
	logic [16:0]               snd_size_q [SOUNDS];
	logic                      voice_act_q [VOICES];
	logic [SID_W-1:0]          voice_snd_q [VOICES];
	logic [16:0]               voice_pos_q [VOICES];

	logic [SID_W-1:0]          tsid;
	logic [SID_W-1:0]          cur_snd;
	logic [16:0]               pos_nxt;
	logic [ADDR_BITS-1:0]      rd_addr;
	logic                      mem_we;
	logic                      hit;
	logic [VID_W-1:0]          hit_v;
	logic                      out_free;
	logic signed [15:0]        clamped;

	assign q_pop     = (state_q == ST_IDLE) && !q_empty;
	assign tsid      = SID_W'(q_cmd.sid);
	assign cur_snd   = voice_snd_q[vidx_q];
	assign pos_nxt   = voice_pos_q[vidx_q] + 17'd1;
	assign rd_addr   = snd_start_q[cur_snd] + ADDR_BITS'(voice_pos_q[vidx_q]);
	assign mem_we    = q_pop && (q_cmd.op == MODE_WSMP);
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;
	assign stat.busy = (state_q != ST_IDLE);
	assign stat.fin  = (state_q == ST_FIN);

	// first voice that is idle or already plays the sound
	always_comb begin
		hit   = 1'b0;
		hit_v = '0;
		for (int v = 0; v < VOICES; v++) begin
			if (!hit && (!voice_act_q[v] || voice_snd_q[v] == tsid)) begin
				hit   = 1'b1;
				hit_v = VID_W'(v);
			end
		end
	end

	always_comb begin
		priority if (acc_q > MAX_V) begin
			clamped = 16'sh7fff;
		end else if (acc_q < MIN_V) begin
			clamped = -16'sh8000;
		end else begin
			clamped = acc_q[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[ADDR_BITS'(q_cmd.addr)] <= q_cmd.data;
		end
		smp_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		prod_s2 <= smp_s1 * $signed({1'b0, gain});
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_cmd.op == MODE_WSND) begin
			snd_start_q[tsid] <= ADDR_BITS'(q_cmd.addr);
			snd_size_q[tsid]  <= q_cmd.length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int v = 0; v < VOICES; v++) begin
				voice_act_q[v] <= 1'b0;
				voice_snd_q[v] <= '0;
				voice_pos_q[v] <= '0;
			end
		end else begin
			if (q_pop && q_cmd.op == MODE_TRIG && hit) begin
				voice_act_q[hit_v] <= 1'b1;
				voice_snd_q[hit_v] <= tsid;
				voice_pos_q[hit_v] <= '0;
			end
			// advance the voice as its sample read is issued
			if (state_q == ST_MIX && voice_act_q[vidx_q]) begin
				voice_pos_q[vidx_q] <= pos_nxt;
				if (pos_nxt >= snd_size_q[cur_snd]) begin
					voice_act_q[vidx_q] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			vidx_q      <= '0;
			drain_q     <= 1'b0;
			acc_q       <= '0;
			act_s1      <= 1'b0;
			act_s2      <= 1'b0;
			out_valid_q <= 1'b0;
			out_item_q  <= '0;
		end else begin
			act_s1 <= (state_q == ST_MIX) && voice_act_q[vidx_q];
			act_s2 <= act_s1;
			if (act_s2) begin
				acc_q <= acc_q + ACC_W'(prod_s2 >>> GAIN_SHIFT);
			end
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop && q_cmd.op == MODE_MIX) begin
						acc_q   <= ACC_W'(q_cmd.data);
						vidx_q  <= '0;
						state_q <= ST_MIX;
					end
				end
				ST_MIX: begin
					if (vidx_q == LAST_V) begin
						drain_q <= 1'b0;
						state_q <= ST_DRAIN;
					end else begin
						vidx_q <= vidx_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					drain_q <= 1'b1;
					if (drain_q) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_item_q.left_sample  <= clamped;
						out_item_q.right_sample <= clamped;
						state_q                 <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* rtl/sample_voice_mixer_top.sv */
// The back end takes no new command while a mix item is in progress; a mix
// steps through the voices (one sample memory read and one multiply per
// voice), while write and trigger items are run as they are popped.
// A four-entry command queue lets input acceptance run ahead of execution.
// Reset: voices idle, gain 3277; the sample memory and sound table are not
// cleared and must be written before use.
// ----------------------------------------------------------------------------
// sample_voice_mixer_top: PCM voice mixer
// Decode front, command queue and execution back with the gain register.
// ----------------------------------------------------------------------------
module sample_voice_mixer_top import svm_pkg::*; #(
	parameter int VOICES           = VOICES_DEF,
	parameter int SOUNDS           = SOUNDS_DEF,
	parameter int SAMPLE_ADDR_BITS = ADDR_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_item,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_item
);

	logic [15:0] gain_q;
	logic        push;
	cmd_t        push_cmd;
	logic        pop;
	cmd_t        head_cmd;
	logic        q_full;
	logic        q_empty;
	back_stat_t  bstat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			gain_q <= cfg_data;
		end
	end

	svm_front #(
		.SOUNDS(SOUNDS)
	) u_front (
		.in_valid(in_valid),
		.in_item (in_item),
		.in_stall(in_stall),
		.q_full  (q_full),
		.push    (push),
		.cmd     (push_cmd)
	);

	svm_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.head_cmd(head_cmd),
		.full    (q_full),
		.empty   (q_empty)
	);

	svm_back #(
		.VOICES   (VOICES),
		.SOUNDS   (SOUNDS),
		.ADDR_BITS(SAMPLE_ADDR_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.gain     (gain_q),
		.q_empty  (q_empty),
		.q_cmd    (head_cmd),
		.q_pop    (pop),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.out_item (out_item),
		.stat     (bstat)
	);

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("command pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("command popped from an empty queue");

	a_result_from_mix: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(bstat.fin))
		else $error("result raised without a finished mix");

	a_pop_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !bstat.busy)
		else $error("command popped while the back end is busy");
`endif

endmodule
